/* rtl/palr_pkg.sv */
// palr_pkg: shared types and constants for the path arc length resampler
// no dependencies
package palr_pkg;

    localparam int COUNT_WIDTH = 24;
    localparam int LEN_WIDTH   = 48;
    localparam int SP_WIDTH    = 31;
    localparam logic [SP_WIDTH-1:0] SPACING_RESET = 31'd15360;
    localparam logic [16:0] CURSOR_ONE = 17'd65536;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] heading;
        logic signed [31:0] pitch;
        logic signed [31:0] roll;
        logic               path_end;
    } node_t;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic signed [31:0] out_heading;
        logic signed [31:0] out_pitch;
        logic signed [31:0] out_roll;
        logic               node_kind;
        logic               last_of_run;
    } res_t;

    // request handed from front to back
    typedef struct packed {
        logic [5:0][31:0] prev;
        logic [5:0][31:0] cur;
        logic             emit;
        logic             end_copy;
        logic [16:0]      cursor;
        logic [33:0]      inc;
        logic [48:0]      num;
    } job_t;

endpackage

/* rtl/palr_if.sv */
// palr_if: valid/ready channel carrying one payload
// depends on palr_pkg
interface palr_node_if;
    import palr_pkg::*;
    logic  valid;
    logic  ready;
    node_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface palr_res_if;
    import palr_pkg::*;
    logic valid;
    logic ready;
    res_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* rtl/palr_front.sv */
// palr_front: accepts nodes, tracks path length, computes length by
// iterative square root and the cursor by iterative division; depends on palr_pkg
module palr_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [palr_pkg::SP_WIDTH-1:0] cfg_data,
    palr_node_if.sink                     in_ch,
    output logic                          job_valid,
    input  logic                          job_ready,
    output palr_pkg::job_t                job
);
    import palr_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SQRT = 5'b00010,
        S_TEST = 5'b00100,
        S_DIV  = 5'b01000,
        S_PUSH = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic [SP_WIDTH-1:0]    spacing_reg;
    logic [5:0][31:0]       prev_reg, cur_reg;
    logic                   end_reg;
    logic                   have_reg;
    logic [LEN_WIDTH-1:0]   len_reg;
    logic [COUNT_WIDTH-1:0] count_reg;
    logic [1:0]             sq_phase_reg;
    logic [67:0]            sum_reg;
    logic [33:0]            root_reg;
    logic [5:0]             bit_reg;
    logic [LEN_WIDTH-1:0]   last_reg;
    logic [48:0]            num_reg;
    logic [16:0]            quo_reg;
    logic [50:0]            rem_reg;
    logic                   emit_reg;
    logic [16:0]            cursor_reg;

    logic [32:0] dsel;
    logic [32:0] dabs;
    logic [33:0] cand;
    logic [67:0] cand_sq;
    logic [LEN_WIDTH:0] len_sum;
    logic [LEN_WIDTH-1:0] len_sat;
    logic [55:0] thr;
    logic [50:0] rem_sh;

    always_comb
    begin
        unique case (sq_phase_reg)
            2'd0:    dsel = 33'(signed'(cur_reg[0])) - 33'(signed'(prev_reg[0]));
            2'd1:    dsel = 33'(signed'(cur_reg[1])) - 33'(signed'(prev_reg[1]));
            default: dsel = 33'(signed'(cur_reg[2])) - 33'(signed'(prev_reg[2]));
        endcase
        dabs    = dsel[32] ? (~dsel + 33'd1) : dsel;
        cand    = root_reg | (34'd1 << bit_reg);
        cand_sq = 68'(cand) * 68'(cand);
        len_sum = {1'b0, last_reg} + (LEN_WIDTH+1)'(root_reg);
        len_sat = len_sum[LEN_WIDTH] ? {LEN_WIDTH{1'b1}} : len_sum[LEN_WIDTH-1:0];
        thr     = 56'(spacing_reg) * 56'({1'b0, count_reg} + 25'd1);
        rem_sh  = {rem_reg[49:0], 1'b0};
    end

    assign in_ch.ready = (state_reg == S_IDLE);
    assign job_valid   = (state_reg == S_PUSH);

    always_comb
    begin
        job.prev     = prev_reg;
        job.cur      = cur_reg;
        job.emit     = emit_reg;
        job.end_copy = end_reg && ((count_reg != '0) || emit_reg);
        job.cursor   = cursor_reg;
        job.inc      = root_reg;
        job.num      = num_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (in_ch.valid && have_reg) state_next = S_SQRT;
            S_SQRT: if (sq_phase_reg == 2'd3 && bit_reg == 6'd0) state_next = S_TEST;
            S_TEST: state_next = S_DIV;
            S_DIV:  if (!emit_reg || quo_reg[16] || bit_reg == 6'd0) state_next = S_PUSH;
            S_PUSH: if (job_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            spacing_reg <= SPACING_RESET;
            have_reg    <= 1'b0;
            len_reg     <= '0;
            count_reg   <= '0;
            prev_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
                spacing_reg <= cfg_data;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_ch.valid)
                    begin
                        cur_reg[0] <= in_ch.data.pos_x;
                        cur_reg[1] <= in_ch.data.pos_y;
                        cur_reg[2] <= in_ch.data.pos_z;
                        cur_reg[3] <= in_ch.data.heading;
                        cur_reg[4] <= in_ch.data.pitch;
                        cur_reg[5] <= in_ch.data.roll;
                        end_reg    <= in_ch.data.path_end;
                        sq_phase_reg <= 2'd0;
                        sum_reg    <= '0;
                        root_reg   <= '0;
                        bit_reg    <= 6'd33;
                        if (!have_reg)
                        begin
                            len_reg   <= '0;
                            count_reg <= '0;
                            if (!in_ch.data.path_end)
                            begin
                                prev_reg[0] <= in_ch.data.pos_x;
                                prev_reg[1] <= in_ch.data.pos_y;
                                prev_reg[2] <= in_ch.data.pos_z;
                                prev_reg[3] <= in_ch.data.heading;
                                prev_reg[4] <= in_ch.data.pitch;
                                prev_reg[5] <= in_ch.data.roll;
                                have_reg <= 1'b1;
                            end
                        end
                    end
                end
                S_SQRT:
                begin
                    // sums the three squared differences, then one root bit a cycle
                    if (sq_phase_reg != 2'd3)
                    begin
                        sum_reg <= sum_reg + 68'(dabs) * 68'(dabs);
                        sq_phase_reg <= sq_phase_reg + 2'd1;
                    end
                    else
                    begin
                        if (cand_sq <= sum_reg)
                            root_reg <= cand;
                        if (bit_reg != 6'd0)
                            bit_reg <= bit_reg - 6'd1;
                    end
                    last_reg <= len_reg;
                end
                S_TEST:
                begin
                    len_reg  <= len_sat;
                    emit_reg <= (56'(len_sat) >= thr);
                    // thr fits below 2^56; past the length ceiling there is no emit
                    if (thr > 56'({1'b0, {LEN_WIDTH{1'b1}}}))
                        num_reg <= {1'b0, {LEN_WIDTH{1'b1}}};
                    else
                        num_reg <= 49'(thr) - 49'(last_reg);
                    quo_reg  <= '0;
                    bit_reg  <= 6'd15;
                    // num below inc is the starting remainder of num<<16
                    rem_reg  <= 51'(49'(thr) - 49'(last_reg));
                    cursor_reg <= '0;
                    if (56'(len_sat) >= thr && count_reg != {COUNT_WIDTH{1'b1}})
                        count_reg <= count_reg + COUNT_WIDTH'(1);
                end
                S_DIV:
                begin
                    // restoring division of num<<16 by inc, one bit a cycle
                    if (root_reg == '0 || num_reg[48] || num_reg == '0)
                    begin
                        cursor_reg <= '0;
                        quo_reg[16] <= 1'b1;
                    end
                    else if (num_reg >= 49'(root_reg))
                    begin
                        cursor_reg <= CURSOR_ONE;
                        quo_reg[16] <= 1'b1;
                    end
                    else
                    begin
                        if (rem_sh >= 51'(root_reg))
                        begin
                            rem_reg <= rem_sh - 51'(root_reg);
                            cursor_reg <= cursor_reg | (17'd1 << bit_reg);
                        end
                        else
                            rem_reg <= rem_sh;
                        if (bit_reg != 6'd0)
                            bit_reg <= bit_reg - 6'd1;
                    end
                end
                S_PUSH:
                begin
                    if (job_ready)
                    begin
                        if (end_reg)
                        begin
                            prev_reg  <= '0;
                            have_reg  <= 1'b0;
                            len_reg   <= '0;
                            count_reg <= '0;
                        end
                        else
                            prev_reg <= cur_reg;
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

/* rtl/palr_queue.sv */
// palr_queue: two-entry request queue between front and back
// depends on palr_pkg
module palr_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_valid,
    output logic           wr_ready,
    input  palr_pkg::job_t wr_data,
    output logic           rd_valid,
    input  logic           rd_ready,
    output palr_pkg::job_t rd_data
);
    import palr_pkg::*;

    job_t       mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_data  = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (wr_valid && wr_ready)
            mem_reg[wp_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr_valid && wr_ready)
                wp_reg <= ~wp_reg;
            if (rd_valid && rd_ready)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(wr_valid && wr_ready) - 2'(rd_valid && rd_ready);
        end
    end

endmodule

/* rtl/palr_back.sv */
// palr_back: interpolates the six fields one at a time and sends results
// depends on palr_pkg
module palr_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           job_valid,
    output logic           job_ready,
    input  palr_pkg::job_t job,
    palr_res_if.source     out_ch
);
    import palr_pkg::*;

    typedef enum logic [3:0] {
        B_IDLE = 4'b0001,
        B_MUL  = 4'b0010,
        B_ADD  = 4'b0100,
        B_OUT  = 4'b1000
    } bstate_t;

    bstate_t state_reg;
    logic [2:0]          fld_reg;
    logic                kind_reg;
    logic signed [50:0]  prod_reg;
    logic [5:0][31:0]    val_reg;
    logic                valid_reg;
    res_t                res_reg;

    logic signed [32:0] diff;
    logic signed [50:0] rnd;

    always_comb
    begin
        diff = 33'(signed'(job.cur[fld_reg])) - 33'(signed'(job.prev[fld_reg]));
        rnd  = (prod_reg + 51'sd32768) >>> 16;
    end

    assign job_ready    = (state_reg == B_OUT) && !valid_reg
                          && !(kind_reg == 1'b0 && job.emit && job.end_copy);
    assign out_ch.valid = valid_reg;
    assign out_ch.data  = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
                valid_reg <= 1'b0;
            unique case (state_reg)
                B_IDLE:
                begin
                    fld_reg <= 3'd0;
                    if (job_valid)
                    begin
                        kind_reg <= !job.emit;
                        if (job.emit)
                            state_reg <= B_MUL;
                        else if (job.end_copy)
                        begin
                            val_reg   <= job.cur;
                            state_reg <= B_OUT;
                        end
                        else
                            state_reg <= B_OUT;
                    end
                end
                B_MUL:
                begin
                    prod_reg  <= 51'(diff) * signed'({34'd0, job.cursor});
                    state_reg <= B_ADD;
                end
                B_ADD:
                begin
                    val_reg[fld_reg] <= job.prev[fld_reg] + rnd[31:0];
                    if (fld_reg == 3'd5)
                        state_reg <= B_OUT;
                    else
                    begin
                        fld_reg   <= fld_reg + 3'd1;
                        state_reg <= B_MUL;
                    end
                end
                B_OUT:
                begin
                    if (!valid_reg && (job.emit || job.end_copy))
                    begin
                        res_reg.out_x       <= val_reg[0];
                        res_reg.out_y       <= val_reg[1];
                        res_reg.out_z       <= val_reg[2];
                        res_reg.out_heading <= val_reg[3];
                        res_reg.out_pitch   <= val_reg[4];
                        res_reg.out_roll    <= val_reg[5];
                        res_reg.node_kind   <= kind_reg;
                        res_reg.last_of_run <= kind_reg || !job.end_copy;
                        valid_reg           <= 1'b1;
                        if (!kind_reg && job.end_copy)
                        begin
                            kind_reg <= 1'b1;
                            val_reg  <= job.cur;
                        end
                        else
                            state_reg <= B_IDLE;
                    end
                    else if (!valid_reg)
                        state_reg <= B_IDLE;
                end
                default: state_reg <= B_IDLE;
            endcase
        end
    end

endmodule

/* rtl/path_arc_length_resampler.sv */
// path_arc_length_resampler: top level, front, queue and back
// per request the front sums three squared differences, finds the root bit by bit
// and takes up to 16 division steps, and the back interpolates the six fields, each
// by a multiply and an add step; an end copy follows the element of its node
// the front takes a new node only when idle; the first node of a path is only stored
// reset clears path state and sets the spacing to 60.0
module path_arc_length_resampler (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [palr_pkg::SP_WIDTH-1:0] cfg_data,
    palr_node_if.sink                     in_ch,
    palr_res_if.source                    out_ch
);
    import palr_pkg::*;

    job_t f_job, b_job;
    logic f_valid, f_ready, b_valid, b_ready;

    palr_front u_front (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
        .in_ch(in_ch), .job_valid(f_valid), .job_ready(f_ready), .job(f_job)
    );

    palr_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_job),
        .rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_job)
    );

    palr_back u_back (
        .clk(clk), .rst_n(rst_n),
        .job_valid(b_valid), .job_ready(b_ready), .job(b_job), .out_ch(out_ch)
    );

endmodule

/* verif/path_arc_length_resampler_tb.sv */
// path_arc_length_resampler_tb: randomised self-checking bench for the resampler
// depends on palr_pkg, palr_if and the path_arc_length_resampler rtl
`timescale 1ns / 1ps

module path_arc_length_resampler_tb;
    import palr_pkg::*;

    localparam logic [47:0] LEN_SAT   = 48'hFFFF_FFFF_FFFF;
    localparam logic [23:0] COUNT_SAT = 24'hFF_FFFF;
    localparam int          TIMEOUT   = 2000000;
    localparam logic        KIND_ELEMENT = 1'b0;
    localparam logic        KIND_END     = 1'b1;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [SP_WIDTH-1:0] cfg_data;

    palr_node_if in_ch();
    palr_res_if  out_ch();

    path_arc_length_resampler DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg_we  (cfg_we),
        .cfg_data(cfg_data),
        .in_ch   (in_ch.sink),
        .out_ch  (out_ch.source)
    );

    // predictor state
    logic [SP_WIDTH-1:0]      spacing;
    logic signed [5:0][31:0]  prev_node;
    logic                     have_prev;
    logic [47:0]              path_len;
    logic [23:0]              elem_count;

    node_t node_queue[$];
    res_t  expected_nodes[$];

    int errors;
    int cycle_count;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_off;
    bit pause_send;
    bit in_taken;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > TIMEOUT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic void add_node(node_t n);
        node_queue.insert(node_queue.size(), n);
    endfunction

    function automatic void add_expected(res_t r);
        expected_nodes.insert(expected_nodes.size(), r);
    endfunction

    function automatic logic [33:0] root_of(logic [69:0] v);
        logic [33:0] r;
        logic [33:0] c;
        r = '0;
        for (int b = 33; b >= 0; b--)
        begin
            c = r | (34'd1 << b);
            if ({70'd0, c} * {70'd0, c} <= {70'd0, v})
                r = c;
        end
        return r;
    endfunction

    function automatic logic [31:0] blend(logic signed [31:0] a, logic signed [31:0] b,
                                         logic [16:0] c);
        logic signed [63:0] p;
        logic signed [63:0] q;
        p = (64'(b) - 64'(a)) * $signed({47'd0, c});
        q = (p + 64'sd32768) >>> 16;
        return 32'(64'(a) + q);
    endfunction

    task automatic predict_node(input node_t n);
        logic signed [5:0][31:0] cur;
        logic [69:0]  sq;
        logic signed [33:0] d;
        logic [33:0]  inc;
        logic [48:0]  total;
        logic [47:0]  last;
        logic [55:0]  thr;
        logic signed [57:0] num;
        logic [16:0]  c;
        res_t r;
        int first;
        cur = {n.pos_x, n.pos_y, n.pos_z, n.heading, n.pitch, n.roll};
        first = expected_nodes.size();
        if (!have_prev)
        begin
            path_len = '0;
            elem_count = '0;
            prev_node = '0;
            if (!n.path_end)
            begin
                prev_node = cur;
                have_prev = 1'b1;
            end
            return;
        end
        sq = '0;
        for (int i = 5; i >= 3; i--)
        begin
            d = 34'(signed'(cur[i])) - 34'(signed'(prev_node[i]));
            if (d < 0)
                d = -d;
            sq += 70'(d) * 70'(d);
        end
        inc = root_of(sq);
        last = path_len;
        total = 49'(last) + 49'(inc);
        if (total > 49'(LEN_SAT))
            total = 49'(LEN_SAT);
        path_len = total[47:0];
        thr = 56'(spacing) * (56'(elem_count) + 56'd1);
        if (56'(path_len) >= thr)
        begin
            num = 58'(thr) - 58'(last);
            if (inc == 0 || num <= 0)
                c = 17'd0;
            else if (58'(inc) <= num)
                c = CURSOR_ONE;
            else
                c = 17'((58'(num) << 16) / 58'(inc));
            r.out_x       = blend(prev_node[5], cur[5], c);
            r.out_y       = blend(prev_node[4], cur[4], c);
            r.out_z       = blend(prev_node[3], cur[3], c);
            r.out_heading = blend(prev_node[2], cur[2], c);
            r.out_pitch   = blend(prev_node[1], cur[1], c);
            r.out_roll    = blend(prev_node[0], cur[0], c);
            r.node_kind   = KIND_ELEMENT;
            r.last_of_run = 1'b0;
            add_expected(r);
            if (elem_count < COUNT_SAT)
                elem_count++;
        end
        prev_node = cur;
        if (n.path_end)
        begin
            if (elem_count > 0)
            begin
                r = {n.pos_x, n.pos_y, n.pos_z, n.heading, n.pitch, n.roll, KIND_END, 1'b0};
                add_expected(r);
            end
            have_prev = 1'b0;
            path_len = '0;
            elem_count = '0;
            prev_node = '0;
        end
        if (expected_nodes.size() > first)
            expected_nodes[expected_nodes.size()-1].last_of_run = 1'b1;
    endtask

    // driver
    always @(negedge clk)
    begin
        if (!rst_n)
            in_ch.valid <= 1'b0;
        else if (in_ch.valid && !in_taken)
            ; // hold the request
        else
        begin
            in_taken = 1'b0;
            if (node_queue.size() > 0 && !pause_send
                && $urandom_range(99) >= send_idle_pct)
            begin
                in_ch.valid <= 1'b1;
                in_ch.data  <= node_queue[0];
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    // the accepted request leaves the pending queue at the accepting edge
    always @(posedge clk)
        if (rst_n && in_ch.valid && in_ch.ready)
        begin
            predict_node(in_ch.data);
            void'(node_queue.pop_front());
            in_taken = 1'b1;
        end

    always @(negedge clk)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else if (hold_off > 0)
        begin
            out_ch.ready <= 1'b0;
            hold_off <= hold_off - 1;
        end
        else
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // monitor
    always @(posedge clk)
    begin
        res_t e;
        res_t a;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            a = out_ch.data;
            if (expected_nodes.size() == 0)
            begin
                $error("unexpected result x=%0d", a.out_x);
                errors++;
            end
            else
            begin
                e = expected_nodes.pop_front();
                if (a.out_x !== e.out_x)
                begin $error("out_x exp %0d got %0d", e.out_x, a.out_x); errors++; end
                if (a.out_y !== e.out_y)
                begin $error("out_y exp %0d got %0d", e.out_y, a.out_y); errors++; end
                if (a.out_z !== e.out_z)
                begin $error("out_z exp %0d got %0d", e.out_z, a.out_z); errors++; end
                if (a.out_heading !== e.out_heading)
                begin
                    $error("out_heading exp %0d got %0d", e.out_heading, a.out_heading);
                    errors++;
                end
                if (a.out_pitch !== e.out_pitch)
                begin $error("out_pitch exp %0d got %0d", e.out_pitch, a.out_pitch); errors++; end
                if (a.out_roll !== e.out_roll)
                begin $error("out_roll exp %0d got %0d", e.out_roll, a.out_roll); errors++; end
                if (a.node_kind !== e.node_kind)
                begin $error("node_kind exp %0d got %0d", e.node_kind, a.node_kind); errors++; end
                if (a.last_of_run !== e.last_of_run)
                begin
                    $error("last_of_run exp %0d got %0d", e.last_of_run, a.last_of_run);
                    errors++;
                end
            end
        end
    end

    function automatic node_t make_node(logic signed [31:0] x, logic signed [31:0] y,
                                        logic signed [31:0] z, logic e);
        node_t n;
        n.pos_x = x;
        n.pos_y = y;
        n.pos_z = z;
        n.heading = $urandom;
        n.pitch = $urandom;
        n.roll = $urandom;
        n.path_end = e;
        return n;
    endfunction

    function automatic logic signed [31:0] rand_coord(int mode);
        case (mode)
            0: return $urandom;
            1: return $signed($urandom_range(20000)) - 10000;
            default: return $signed($urandom_range(60000)) - 30000;
        endcase
    endfunction

    task automatic wait_drained();
        while (node_queue.size() > 0 || in_ch.valid)
            @(posedge clk);
        while (expected_nodes.size() > 0)
            @(posedge clk);
        repeat (150) @(posedge clk);
    endtask

    task automatic write_spacing(logic [SP_WIDTH-1:0] v);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(negedge clk);
        cfg_we   <= 1'b0;
        spacing = v;
    endtask

    task automatic queue_path(int len, int mode);
        for (int i = 0; i < len; i++)
            add_node(make_node(rand_coord(mode), rand_coord(mode),
                               rand_coord(mode), i == len - 1));
    endtask

    initial
    begin
        int sent;
        logic [SP_WIDTH-1:0] spacings[6];
        errors = 0;
        cycle_count = 0;
        hold_off = 0;
        pause_send = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        spacing = SPACING_RESET;
        have_prev = 1'b0;
        path_len = '0;
        elem_count = '0;
        prev_node = '0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: single-node path, repeated points, extremes, end copy
        add_node(make_node(32'sd5, 32'sd5, 32'sd5, 1'b1));
        add_node(make_node(32'sd0, 32'sd0, 32'sd0, 1'b0));
        add_node(make_node(32'sd0, 32'sd0, 32'sd0, 1'b0));
        add_node(make_node(32'sd15360, 32'sd0, 32'sd0, 1'b0));
        add_node(make_node(32'sd40000, 32'sd100, -32'sd100, 1'b1));
        add_node(make_node(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0));
        add_node(make_node(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0));
        add_node(make_node(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0));
        add_node(make_node(-32'sd1, -32'sd1, -32'sd1, 1'b1));
        add_node(make_node(32'sd0, 32'sd0, 32'sd0, 1'b0));
        add_node(make_node(32'sd100, 32'sd0, 32'sd0, 1'b1));
        wait_drained();

        write_spacing(31'd1);
        queue_path(6, 1);
        wait_drained();
        write_spacing(31'h7FFF_FFFF);
        queue_path(5, 0);
        wait_drained();

        // long receiver hold-off while the sender keeps offering
        write_spacing(31'd1);
        hold_off = 2000;
        queue_path(30, 1);
        wait_drained();

        spacings = '{31'd1, 31'd256, 31'd4000, SPACING_RESET, 31'd100000, 31'h7FFF_FFFF};
        sent = 0;
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
                default: begin send_idle_pct = 14; recv_stall_pct = 14; end
            endcase
            write_spacing(spacings[$urandom_range(5)]);
            while (sent < (ph + 1) * 90)
            begin
                int len;
                len = $urandom_range(12, 1);
                if ($urandom_range(9) == 0)
                    queue_path(len, 0);
                else
                    queue_path(len, $urandom_range(2, 1));
                sent += len;
            end
            wait_drained();
        end

        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
